/* design/irzs_pkg.sv */
// Shared types and constants of the irrigation zone scheduler.
// Holds item codes, zone mode codes, register indexes and fixed field widths.
// No dependencies.
package irzs_pkg;

	// Item codes carried in the mode field
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_ZONE_MODE  = 2'd1;
	localparam logic [1:0] OP_SLOT_WRITE = 2'd2;

	// Zone mode codes; any other nonzero code behaves as auto
	localparam logic [1:0] ZM_OFF = 2'd0;
	localparam logic [1:0] ZM_ON  = 2'd1;

	// Configuration register indexes
	localparam logic [1:0] CFG_WATCHDOG_MINUTES = 2'd0;
	localparam logic [1:0] CFG_PUMP_DELAY_MS    = 2'd1;
	localparam logic [1:0] CFG_TICK_MS          = 2'd2;

	// Register reset values
	localparam logic [10:0] WATCHDOG_RESET   = 11'd60;
	localparam logic [15:0] PUMP_DELAY_RESET = 16'd5000;
	localparam logic [9:0]  TICK_MS_RESET    = 10'd10;

	// Tank level indications
	localparam logic [3:0] LEVEL_LOW  = 4'd2;
	localparam logic [3:0] LEVEL_MID  = 4'd6;
	localparam logic [3:0] LEVEL_FULL = 4'd9;

	// Fixed widths and limits
	localparam int          MIN_PER_HOUR = 60;
	localparam logic [10:0] WD_SAT       = 11'd2047;
	localparam int          MASK_W       = 6;
	localparam int          MIN_W        = 11;
	localparam int          WAIT_W       = 17;
	localparam int          CNT_W        = 32;

endpackage

/* design/irrigation_zone_scheduler.sv */
// Irrigation zone scheduler top level: zone modes, schedule windows, watchdog,
// weekly valve service run, pump delay, tank level and statistics.
// Depends on irzs_pkg.

// One item (tick, zone mode write or schedule slot write) is accepted per clock
// cycle while results are being taken. An accepted item waits in the input
// register, where a single pass of logic evaluates every zone and slot
// window in parallel and updates all state; its result is then registered
// into the output register, from which it is offered. The output register
// lets the block take a new beat while a result waits to be taken; input flow
// stops only when both the input and output registers are full and the
// waiting result is not being taken. Configuration writes are taken every cycle
// (cfg_ready is always high) and must only be issued while no item is in
// flight. The schedule store lives in flip-flops that reset clears at once,
// so there is no clearing pass.
module irrigation_zone_scheduler #(
	parameter int NUM_ZONES = 6,
	parameter int NUM_SLOTS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  zone,
	input  logic        slot,
	input  logic [1:0]  zone_mode,
	input  logic [10:0] start_minute,
	input  logic [10:0] run_minutes,
	input  logic [5:0]  clock_minute,
	input  logic [4:0]  clock_hour,
	input  logic [2:0]  week_day,
	input  logic        tank_high,
	input  logic        tank_low,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  valve_bits,
	output logic        pump_on,
	output logic [3:0]  tank_level,
	output logic [5:0]  forced_off_bits,
	output logic        service_busy,
	output logic [31:0] pump_run_minutes,
	output logic [31:0] switch_count
);

	localparam int NSLOT_TOT = NUM_ZONES * NUM_SLOTS;
	localparam int SVC_W     = $clog2(NUM_ZONES + 1);
	localparam int PAD_W     = (NUM_ZONES > irzs_pkg::MASK_W) ? NUM_ZONES : irzs_pkg::MASK_W;

	localparam int MW = irzs_pkg::MIN_W;
	localparam int WW = irzs_pkg::WAIT_W;
	localparam int CW = irzs_pkg::CNT_W;

	// configuration registers
	logic [10:0] wd_minutes_q;
	logic [15:0] pump_delay_q;
	logic [9:0]  tick_ms_q;

	// input register
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [2:0]  zone_s1;
	logic        slot_s1;
	logic [1:0]  zone_mode_s1;
	logic [10:0] start_s1;
	logic [10:0] run_s1;
	logic [5:0]  cmin_s1;
	logic [4:0]  chour_s1;
	logic [2:0]  wday_s1;
	logic        hi_s1;
	logic        lo_s1;

	// block state
	logic [5:0]    last_minute_q;
	logic [MW-1:0] mod_q;
	logic [1:0]    zmode_q      [NUM_ZONES];
	logic [MW-1:0] slot_start_q [NSLOT_TOT];
	logic [MW-1:0] slot_len_q   [NSLOT_TOT];
	logic [MW-1:0] wd_cnt_q     [NUM_ZONES];
	logic          prior_q      [NUM_ZONES];
	logic [CW-1:0] switches_q   [NUM_ZONES];
	logic          svc_flag_q;
	logic [SVC_W-1:0] svc_zone_q;
	logic [WW-1:0] pump_wait_q;
	logic [CW-1:0] pump_min_q;
	logic [3:0]    level_q;

	// next state
	logic [5:0]    last_minute_d;
	logic [MW-1:0] mod_d;
	logic [1:0]    zmode_d      [NUM_ZONES];
	logic [MW-1:0] slot_start_d [NSLOT_TOT];
	logic [MW-1:0] slot_len_d   [NSLOT_TOT];
	logic [MW-1:0] wd_cnt_d     [NUM_ZONES];
	logic          prior_d      [NUM_ZONES];
	logic [CW-1:0] switches_d   [NUM_ZONES];
	logic          svc_flag_d;
	logic [SVC_W-1:0] svc_zone_d;
	logic [WW-1:0] pump_wait_d;
	logic [CW-1:0] pump_min_d;
	logic [3:0]    level_d;

	// result of the item in the input register
	logic [NUM_ZONES-1:0] valves_raw;
	logic [NUM_ZONES-1:0] valves_ovr;
	logic [NUM_ZONES-1:0] forced;
	logic [PAD_W-1:0]     valves_pad;
	logic [PAD_W-1:0]     forced_pad;
	logic                 pump;
	logic [CW-1:0]        sw_sel;

	// output register
	logic          valid_s2;
	logic [5:0]    valve_bits_s2;
	logic          pump_on_s2;
	logic [3:0]    level_s2;
	logic [5:0]    forced_s2;
	logic          svc_busy_s2;
	logic [CW-1:0] pump_min_s2;
	logic [CW-1:0] switch_s2;

	logic step;

	// Move the input register whenever the output register is free or drains
	assign step      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	// Evaluate one item against the current state
	always_comb begin
		logic          is_tick;
		logic          newmin;
		logic          demand;
		logic          open;
		logic [MW-1:0] mod_now;
		logic [MW-1:0] cnt_inc;
		logic [MW:0]   win_end;
		logic          svc_on;

		last_minute_d = last_minute_q;
		mod_d         = mod_q;
		zmode_d       = zmode_q;
		slot_start_d  = slot_start_q;
		slot_len_d    = slot_len_q;
		wd_cnt_d      = wd_cnt_q;
		prior_d       = prior_q;
		switches_d    = switches_q;
		svc_flag_d    = svc_flag_q;
		svc_zone_d    = svc_zone_q;
		pump_wait_d   = pump_wait_q;
		pump_min_d    = pump_min_q;
		level_d       = level_q;
		valves_raw    = '0;
		valves_ovr    = '0;
		forced        = '0;
		pump          = 1'b0;
		demand        = 1'b0;
		open          = 1'b0;
		cnt_inc       = '0;
		win_end       = '0;
		svc_on        = 1'b0;

		is_tick = (mode_s1 == irzs_pkg::OP_TICK);
		newmin  = (cmin_s1 != last_minute_q);
		mod_now = mod_q;
		if (newmin) begin
			mod_now = MW'(32'(chour_s1) * irzs_pkg::MIN_PER_HOUR) + MW'(cmin_s1);
		end

		// Apply zone mode and schedule slot writes
		for (int z = 0; z < NUM_ZONES; z++) begin
			if (mode_s1 == irzs_pkg::OP_ZONE_MODE && 32'(zone_s1) == z) begin
				zmode_d[z] = zone_mode_s1;
			end
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (mode_s1 == irzs_pkg::OP_SLOT_WRITE && 32'(zone_s1) == z &&
				    32'(slot_s1) == s) begin
					slot_start_d[z*NUM_SLOTS+s] = start_s1;
					slot_len_d[z*NUM_SLOTS+s]   = run_s1;
				end
			end
		end

		if (is_tick) begin
			if (newmin) begin
				mod_d         = mod_now;
				last_minute_d = cmin_s1;
			end

			// Per zone: watchdog, auto windows, switch statistics
			for (int z = 0; z < NUM_ZONES; z++) begin
				open = 1'b0;
				if (zmode_q[z] == irzs_pkg::ZM_ON) begin
					open    = 1'b1;
					cnt_inc = wd_cnt_q[z];
					if (newmin && wd_cnt_q[z] < irzs_pkg::WD_SAT) begin
						cnt_inc = wd_cnt_q[z] + MW'(1);
					end
					wd_cnt_d[z] = cnt_inc;
					if (cnt_inc >= wd_minutes_q) begin
						zmode_d[z] = irzs_pkg::ZM_OFF;
						forced[z]  = 1'b1;
					end
				end else begin
					wd_cnt_d[z] = '0;
					if (zmode_q[z] != irzs_pkg::ZM_OFF) begin
						for (int s = 0; s < NUM_SLOTS; s++) begin
							win_end = {1'b0, slot_start_q[z*NUM_SLOTS+s]} +
							          {1'b0, slot_len_q[z*NUM_SLOTS+s]};
							if (mod_now >= slot_start_q[z*NUM_SLOTS+s] &&
							    {1'b0, mod_now} < win_end) begin
								open = 1'b1;
							end
						end
					end
				end
				if (prior_q[z] != open) begin
					switches_d[z] = switches_q[z] + CW'(1);
					prior_d[z]    = open;
				end
				demand        = demand | open;
				valves_raw[z] = open;
			end

			// Weekly service run overrides one valve at a time
			valves_ovr = valves_raw;
			svc_on = svc_flag_q ||
			         (wday_s1 == 3'd0 && chour_s1 == 5'd0 && cmin_s1 == 6'd0 && newmin);
			svc_flag_d = svc_on;
			if (svc_on) begin
				if (svc_zone_q < SVC_W'(NUM_ZONES)) begin
					for (int z = 0; z < NUM_ZONES; z++) begin
						if (32'(svc_zone_q) == z) begin
							valves_ovr[z] = !newmin;
						end
					end
					if (newmin) begin
						svc_zone_d = svc_zone_q + SVC_W'(1);
					end
				end else begin
					svc_flag_d = 1'b0;
				end
			end else begin
				svc_zone_d = '0;
			end

			// Pump start delay
			if (demand && pump_wait_q >= WW'(pump_delay_q)) begin
				pump = 1'b1;
			end else if (demand) begin
				pump_wait_d = pump_wait_q + WW'(tick_ms_q);
			end else begin
				pump_wait_d = '0;
			end

			// Tank level; a wet upper switch over a dry lower one holds the level
			unique case ({hi_s1, lo_s1})
				2'b11:   level_d = irzs_pkg::LEVEL_FULL;
				2'b01:   level_d = irzs_pkg::LEVEL_MID;
				2'b00:   level_d = irzs_pkg::LEVEL_LOW;
				default: level_d = level_q;
			endcase

			if (pump && newmin) begin
				pump_min_d = pump_min_q + CW'(1);
			end
		end

		// Report the switch count of the addressed zone
		sw_sel = '0;
		for (int z = 0; z < NUM_ZONES; z++) begin
			if (32'(zone_s1) == z) begin
				sw_sel = switches_d[z];
			end
		end

		valves_pad = PAD_W'(valves_ovr);
		forced_pad = PAD_W'(forced);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_minutes_q <= irzs_pkg::WATCHDOG_RESET;
			pump_delay_q <= irzs_pkg::PUMP_DELAY_RESET;
			tick_ms_q    <= irzs_pkg::TICK_MS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				irzs_pkg::CFG_WATCHDOG_MINUTES: wd_minutes_q <= cfg_data[10:0];
				irzs_pkg::CFG_PUMP_DELAY_MS:    pump_delay_q <= cfg_data;
				irzs_pkg::CFG_TICK_MS:          tick_ms_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1      <= mode;
			zone_s1      <= zone;
			slot_s1      <= slot;
			zone_mode_s1 <= zone_mode;
			start_s1     <= start_minute;
			run_s1       <= run_minutes;
			cmin_s1      <= clock_minute;
			chour_s1     <= clock_hour;
			wday_s1      <= week_day;
			hi_s1        <= tank_high;
			lo_s1        <= tank_low;
		end
	end

	// Block state: advance once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_minute_q <= '0;
			mod_q         <= '0;
			svc_flag_q    <= 1'b0;
			svc_zone_q    <= '0;
			pump_wait_q   <= '0;
			pump_min_q    <= '0;
			level_q       <= irzs_pkg::LEVEL_LOW;
			for (int z = 0; z < NUM_ZONES; z++) begin
				zmode_q[z]    <= irzs_pkg::ZM_OFF;
				wd_cnt_q[z]   <= '0;
				prior_q[z]    <= 1'b0;
				switches_q[z] <= '0;
			end
			for (int i = 0; i < NSLOT_TOT; i++) begin
				slot_start_q[i] <= '0;
				slot_len_q[i]   <= '0;
			end
		end else if (step) begin
			last_minute_q <= last_minute_d;
			mod_q         <= mod_d;
			svc_flag_q    <= svc_flag_d;
			svc_zone_q    <= svc_zone_d;
			pump_wait_q   <= pump_wait_d;
			pump_min_q    <= pump_min_d;
			level_q       <= level_d;
			zmode_q       <= zmode_d;
			wd_cnt_q      <= wd_cnt_d;
			prior_q       <= prior_d;
			switches_q    <= switches_d;
			slot_start_q  <= slot_start_d;
			slot_len_q    <= slot_len_d;
		end
	end

	// Output register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (step) begin
			valve_bits_s2 <= valves_pad[5:0];
			pump_on_s2    <= pump;
			level_s2      <= level_d;
			forced_s2     <= forced_pad[5:0];
			svc_busy_s2   <= svc_flag_d;
			pump_min_s2   <= pump_min_d;
			switch_s2     <= sw_sel;
		end
	end

	assign out_valid        = valid_s2;
	assign valve_bits       = valve_bits_s2;
	assign pump_on          = pump_on_s2;
	assign tank_level       = level_s2;
	assign forced_off_bits  = forced_s2;
	assign service_busy     = svc_busy_s2;
	assign pump_run_minutes = pump_min_s2;
	assign switch_count     = switch_s2;

`ifndef NO_ASSERTIONS
	// The service pointer never passes the end of the zone list
	a_svc_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		svc_zone_q <= SVC_W'(NUM_ZONES))
		else $error("service zone pointer out of range");

	// A running pump means the start delay had elapsed and the wait held
	a_pump_delay: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pump_on_s2 |-> pump_wait_q >= WW'(pump_delay_q))
		else $error("pump running before its start delay");

	// Without the service override a forced-off zone still shows its valve open
	a_forced_open: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !svc_busy_s2 |-> (forced_s2 & ~valve_bits_s2) == 6'd0)
		else $error("forced-off zone without an open valve");

	// A stalled item stays in the input register untouched
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(mode_s1) && $stable(zone_s1))
		else $error("input register lost a stalled item");

	// The tank level is always one of its three indications
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		level_q == irzs_pkg::LEVEL_LOW || level_q == irzs_pkg::LEVEL_MID ||
		level_q == irzs_pkg::LEVEL_FULL)
		else $error("tank level holds an unknown indication");
`endif

endmodule
